@@ src/wstd_pkg.sv @@
// Shared widths, register indexes, event codes and helpers of the settle trigger detector.
package wstd_pkg;

  localparam int WEIGHT_BITS = 21;
  localparam int DELTA_BITS  = WEIGHT_BITS + 1;
  localparam int COUNT_BITS  = 7;
  localparam int DIV_BITS    = COUNT_BITS + 1;
  localparam int ACC_BITS    = WEIGHT_BITS + COUNT_BITS + 1;
  localparam int TIME_BITS   = 32;

  localparam int EMPTY_BITS  = 14;
  localparam int SETTLE_BITS = 14;
  localparam int THR_BITS    = 17;
  localparam int COOL_BITS   = 16;
  localparam int CFG_BITS    = 17;
  localparam int CFG_IDX_BITS = 3;

  localparam int IN_DATA_BITS  = 56;
  localparam int OUT_DATA_BITS = 72;

  localparam logic [EMPTY_BITS-1:0]  EMPTY_BAND_RST  = 14'd80;
  localparam logic [SETTLE_BITS-1:0] SETTLE_BAND_RST = 14'd20;
  localparam logic [THR_BITS-1:0]    THRESHOLD_RST   = 17'd100;
  localparam logic [COUNT_BITS-1:0]  TARGET_RST      = 7'd5;
  localparam logic [COOL_BITS-1:0]   COOLDOWN_RST    = 16'd2000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_EMPTY_BAND  = 3'd0,
    CFG_SETTLE_BAND = 3'd1,
    CFG_THRESHOLD   = 3'd2,
    CFG_TARGET      = 3'd3,
    CFG_COOLDOWN    = 3'd4
  } cfg_idx_t;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_REMOVAL = 2'd1;
  localparam logic [1:0] KIND_CAPTURE = 2'd2;

  // magnitude of a two's complement weight, as an unsigned value of the same width
  function automatic logic [WEIGHT_BITS-1:0] mag_w(input logic [WEIGHT_BITS-1:0] x);
    mag_w = x[WEIGHT_BITS-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [DELTA_BITS-1:0] mag_d(input logic [DELTA_BITS-1:0] x);
    mag_d = x[DELTA_BITS-1] ? (~x + 1'b1) : x;
  endfunction

endpackage

@@ src/wstd_sermul.sv @@
// Bit-serial signed by unsigned multiply-accumulate, one multiplier bit per cycle.
module wstd_sermul (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [wstd_pkg::WEIGHT_BITS-1:0] mcand,
  input  logic        [wstd_pkg::COUNT_BITS-1:0]  mplier,
  input  logic signed [wstd_pkg::WEIGHT_BITS-1:0] addend,
  output logic                                  done,
  output logic signed [wstd_pkg::ACC_BITS-1:0]    result
);

  localparam int CNT_BITS = $clog2(wstd_pkg::COUNT_BITS);
  localparam int EXT_BITS = wstd_pkg::ACC_BITS - wstd_pkg::WEIGHT_BITS;

  logic                                busy_r;
  logic                                done_r;
  logic [CNT_BITS-1:0]                 cnt_r;
  logic [wstd_pkg::ACC_BITS-1:0]       acc_r;
  logic [wstd_pkg::ACC_BITS-1:0]       mcand_r;
  logic [wstd_pkg::COUNT_BITS-1:0]     mplier_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r   <= 1'b1;
        cnt_r    <= '0;
        acc_r    <= {{EXT_BITS{addend[wstd_pkg::WEIGHT_BITS-1]}}, addend};
        mcand_r  <= {{EXT_BITS{mcand[wstd_pkg::WEIGHT_BITS-1]}}, mcand};
        mplier_r <= mplier;
      end else if (busy_r) begin
        // add the shifted multiplicand where the current multiplier bit is set
        if (mplier_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r  <= {mcand_r[wstd_pkg::ACC_BITS-2:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[wstd_pkg::COUNT_BITS-1:1]};
        cnt_r    <= cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(wstd_pkg::COUNT_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

@@ src/wstd_serdiv.sv @@
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module wstd_serdiv (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [wstd_pkg::ACC_BITS-1:0]  numer,
  input  logic        [wstd_pkg::DIV_BITS-1:0]  denom,
  output logic                                done,
  output logic signed [wstd_pkg::ACC_BITS-1:0]  quotient
);

  localparam int NB       = wstd_pkg::ACC_BITS;
  localparam int DB       = wstd_pkg::DIV_BITS;
  localparam int CNT_BITS = $clog2(NB);

  logic                busy_r;
  logic                done_r;
  logic                neg_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [NB-1:0]       num_r;
  logic [DB-1:0]       rem_r;
  logic [DB-1:0]       den_r;
  logic [DB:0]         trial;
  logic [DB:0]         diff;
  logic                ge;

  assign trial = {rem_r, num_r[NB-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= numer[NB-1];
        num_r  <= numer[NB-1] ? (~numer + 1'b1) : numer;
        rem_r  <= '0;
        den_r  <= denom;
      end else if (busy_r) begin
        // shift in one dividend bit, keep the quotient bit in the freed slot
        rem_r <= ge ? diff[DB-1:0] : trial[DB-1:0];
        num_r <= {num_r[NB-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(NB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~num_r + 1'b1) : num_r;

endmodule

@@ src/weight_settle_trigger_detector.sv @@
// Top level of the weight settle trigger detector: control sequencer, state and stream ports.
// Averaging path: a reading that averages into the candidate goes through the serial
//   multiply and then the serial divide; a reading that restarts the candidate skips both.
// Input beats are taken only in the idle state, so a new beat waits until the last is done.
//   A finished result waits in the output register.
// Reset: synchronous, active low; registers return to their defaults, reference, candidate,
//   pending flag and last trigger time clear, the settle count loads the default target.
module weight_settle_trigger_detector (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // config write port
  input  logic                                   cfg_we,
  input  logic [wstd_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [wstd_pkg::CFG_BITS-1:0]          cfg_wdata,
  // input beats
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // in_tdata: sample_weight[20:0], time_ms[52:21], downstream_ready[53], zero pad
  input  logic [wstd_pkg::IN_DATA_BITS-1:0]      in_tdata,
  // result beats
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // out_tdata: event_weight[20:0], event_delta[42:21], event_accepted[43],
  //            settled_weight[64:44], zero pad
  output logic [wstd_pkg::OUT_DATA_BITS-1:0]     out_tdata,
  // out_tuser: event_kind[1:0]
  output logic [1:0]                             out_tuser
);

  localparam int W  = wstd_pkg::WEIGHT_BITS;
  localparam int D  = wstd_pkg::DELTA_BITS;
  localparam int C  = wstd_pkg::COUNT_BITS;
  localparam int T  = wstd_pkg::TIME_BITS;
  localparam int PAD = wstd_pkg::OUT_DATA_BITS - (3 * W + 2);

  typedef enum logic [2:0] {
    S_IDLE, S_DZ, S_CMP, S_MUL, S_DIV, S_UPD, S_EVT, S_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic [wstd_pkg::EMPTY_BITS-1:0]  empty_band_r;
  logic [wstd_pkg::SETTLE_BITS-1:0] settle_band_r;
  logic [wstd_pkg::THR_BITS-1:0]    threshold_r;
  logic [C-1:0]                     target_r;
  logic [wstd_pkg::COOL_BITS-1:0]   cooldown_r;

  // tracking state
  logic [W-1:0] ref_r;
  logic [W-1:0] cand_r;
  logic [C-1:0] count_r;
  logic         pending_r;
  logic [T-1:0] last_r;

  // latched beat and per-item working registers
  logic [W-1:0] sample_r;
  logic [T-1:0] time_r;
  logic         ready_r;
  logic [W-1:0] cur_r;
  logic [D-1:0] delta_r;
  logic [W-1:0] norm_r;
  logic         fire_r;
  logic         cool_ok_r;

  // output register
  logic         out_valid_r;
  logic [1:0]   out_kind_r;
  logic [W-1:0] out_weight_r;
  logic [D-1:0] out_delta_r;
  logic         out_acc_r;
  logic [W-1:0] out_settled_r;

  logic mul_start, mul_done, div_start, div_done;
  logic signed [wstd_pkg::ACC_BITS-1:0] mul_result, div_quot;

  // reading versus candidate and reference
  logic [D-1:0] cand_diff, ref_diff, cand_dev, ref_dev;
  logic         near, trig;
  // event resolution
  logic [D-1:0] cand_delta;
  logic [T-1:0] elapsed;
  logic         hit, removal, accepted, out_free;
  logic [1:0]   kind;

  assign cand_diff = {cur_r[W-1], cur_r} - {cand_r[W-1], cand_r};
  assign ref_diff  = {cur_r[W-1], cur_r} - {ref_r[W-1], ref_r};
  assign cand_dev  = wstd_pkg::mag_d(cand_diff);
  assign ref_dev   = wstd_pkg::mag_d(ref_diff);
  assign near      = cand_dev <= D'(settle_band_r);
  assign trig      = !pending_r && (ref_dev >= D'(threshold_r));

  assign cand_delta = {cand_r[W-1], cand_r} - {ref_r[W-1], ref_r};
  assign elapsed    = time_r - last_r;

  // removal: settled weight at or below zero, or the scale got lighter
  assign removal  = norm_r[W-1] || (norm_r == '0) || delta_r[D-1];
  assign hit      = fire_r && cool_ok_r && (wstd_pkg::mag_d(delta_r) >= D'(threshold_r));
  assign accepted = hit && (removal || ready_r);
  assign kind     = !hit ? wstd_pkg::KIND_NONE :
                    (removal ? wstd_pkg::KIND_REMOVAL : wstd_pkg::KIND_CAPTURE);
  assign out_free = !out_valid_r || out_tready;

  assign mul_start = (state_r == S_CMP) && !trig && near;
  assign div_start = (state_r == S_MUL) && mul_done;

  wstd_sermul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (cand_r),
    .mplier (count_r),
    .addend (cur_r),
    .done   (mul_done),
    .result (mul_result)
  );

  wstd_serdiv u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .numer    (mul_result),
    .denom    ({1'b0, count_r} + wstd_pkg::DIV_BITS'(1)),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      empty_band_r  <= wstd_pkg::EMPTY_BAND_RST;
      settle_band_r <= wstd_pkg::SETTLE_BAND_RST;
      threshold_r   <= wstd_pkg::THRESHOLD_RST;
      target_r      <= wstd_pkg::TARGET_RST;
      cooldown_r    <= wstd_pkg::COOLDOWN_RST;
      ref_r         <= '0;
      cand_r        <= '0;
      count_r       <= wstd_pkg::TARGET_RST;
      pending_r     <= 1'b0;
      last_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wstd_pkg::CFG_EMPTY_BAND:  empty_band_r  <= cfg_wdata[wstd_pkg::EMPTY_BITS-1:0];
          wstd_pkg::CFG_SETTLE_BAND: settle_band_r <= cfg_wdata[wstd_pkg::SETTLE_BITS-1:0];
          wstd_pkg::CFG_THRESHOLD:   threshold_r   <= cfg_wdata[wstd_pkg::THR_BITS-1:0];
          wstd_pkg::CFG_TARGET:      target_r      <= cfg_wdata[C-1:0];
          wstd_pkg::CFG_COOLDOWN:    cooldown_r    <= cfg_wdata[wstd_pkg::COOL_BITS-1:0];
          default: ;
        endcase
      end

      // drop the result once the sink takes it
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            sample_r <= in_tdata[W-1:0];
            time_r   <= in_tdata[W+T-1:W];
            ready_r  <= in_tdata[W+T];
            state_r  <= S_DZ;
          end
        end
        S_DZ: begin
          // dead zone: small readings count as an empty scale
          cur_r   <= (wstd_pkg::mag_w(sample_r) <= W'(empty_band_r)) ? '0 : sample_r;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (trig) begin
            // a change from the reference restarts the candidate and waits to settle
            pending_r <= 1'b1;
            cand_r    <= cur_r;
            count_r   <= C'(1);
            state_r   <= S_EVT;
          end else if (!near) begin
            cand_r  <= cur_r;
            count_r <= C'(1);
            state_r <= S_EVT;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          cand_r <= div_quot[W-1:0];
          if (count_r < target_r) begin
            count_r <= count_r + 1'b1;
          end
          state_r <= S_EVT;
        end
        S_EVT: begin
          delta_r   <= cand_delta;
          norm_r    <= (wstd_pkg::mag_w(cand_r) <= W'(empty_band_r)) ? '0 : cand_r;
          fire_r    <= pending_r && (count_r >= target_r);
          cool_ok_r <= elapsed >= T'(cooldown_r);
          state_r   <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_kind_r    <= kind;
            out_weight_r  <= hit ? norm_r : '0;
            out_delta_r   <= hit ? delta_r : '0;
            out_acc_r     <= accepted;
            out_settled_r <= cand_r;
            if (accepted) begin
              last_r <= time_r;
              ref_r  <= norm_r;
            end
            if (fire_r) begin
              pending_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {{PAD{1'b0}}, out_settled_r, out_acc_r, out_delta_r, out_weight_r};

`ifndef SYNTHESIS
  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == S_MUL)
    else $error("multiplier finished outside its wait state");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside its wait state");

  a_ref_moves_on_event: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_FIN) |=> $stable(ref_r) && $stable(last_r))
    else $error("reference or trigger time changed without an event");

  a_none_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == wstd_pkg::KIND_NONE) |-> out_tdata[2*W+1:0] == '0)
    else $error("event fields set on a result without event");
`endif

endmodule
